// File: hw/rtl/b32_pkg.sv
// shared types, register indexes and helpers for the base32 codec
package b32_pkg;

  // fixed sizes of the scheme
  localparam int unsigned SymCount  = 32;
  localparam int unsigned AccBits   = 12;
  localparam int unsigned CntBits   = 4;
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned QueueDep  = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_LO  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_ML  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_MH  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_HI  = 3'd4;

  // codec direction
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // 32 alphabet characters, entry i in bits 8i+7..8i
  typedef logic [SymCount-1:0][7:0] alpha_t;

  // input beat
  typedef struct packed {
    logic [7:0] data_in;
    logic       is_last;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [7:0] data_out;
    logic       has_data;
    logic       last;
  } out_item_t;

  // results produced by one item
  typedef struct packed {
    logic [1:0]                     cnt;
    logic [MaxRes-1:0][$bits(out_item_t)-1:0] items;
  } step_res_t;

  // alphabet character for a 5-bit group
  function automatic logic [7:0] symbol_at(alpha_t a, logic [4:0] idx);
    return a[idx];
  endfunction

endpackage

// File: hw/rtl/b32_step.sv
// per-item codec step: bit accumulator state and result generation
module b32_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mode,
  input  b32_pkg::alpha_t    alpha,
  input  b32_pkg::in_item_t  item,
  input  logic               commit,
  input  logic               clear,
  output b32_pkg::step_res_t res
);
  import b32_pkg::*;

  logic [AccBits-1:0] acc_r, acc_nxt;
  logic [CntBits-1:0] cnt_r, cnt_nxt;

  logic [AccBits-1:0] acc_e, acc_d, acc_new;
  logic [CntBits-1:0] t_e, t_d, rem;
  logic [4:0]         g0, g1, fin, idx;
  logic [7:0]         dbyte;
  logic [2:0]         fin_sh;
  logic [1:0]         n;
  out_item_t          it [MaxRes];

  // reverse alphabet lookup, highest matching entry wins
  always_comb begin
    idx = '0;
    for (int i = 0; i < SymCount; i++) begin
      if (alpha[i] == item.data_in) idx = 5'(i);
    end
  end

  // bit splitting for both directions
  always_comb begin
    acc_e  = {acc_r[3:0], item.data_in};
    acc_d  = {acc_r[6:0], idx};
    t_e    = cnt_r + 4'd8;
    t_d    = cnt_r + 4'd5;
    g0     = 5'(acc_e >> (t_e - 4'd5));
    g1     = 5'(acc_e >> (t_e - 4'd10));
    dbyte  = 8'(acc_d >> (t_d - 4'd8));
    n      = '0;
    rem    = '0;
    fin_sh = '0;
    fin    = '0;
    for (int k = 0; k < MaxRes; k++) it[k] = '0;

    if (mode == MODE_ENCODE) begin
      it[0] = '{data_out: symbol_at(alpha, g0), has_data: 1'b1, last: 1'b0};
      if (t_e >= 4'd10) begin
        it[1] = '{data_out: symbol_at(alpha, g1), has_data: 1'b1, last: 1'b0};
        rem   = t_e - 4'd10;
        n     = 2'd2;
      end else begin
        rem = t_e - 4'd5;
        n   = 2'd1;
      end
      // zero-filled tail group on the final byte
      fin_sh = 3'(4'd5 - rem);
      fin    = 5'(acc_e << fin_sh);
      if (item.is_last && rem != '0) begin
        it[n] = '{data_out: symbol_at(alpha, fin), has_data: 1'b1, last: 1'b0};
        n     = n + 2'd1;
      end
      acc_new = acc_e & ((AccBits'(1) << rem) - AccBits'(1));
    end else begin
      if (t_d >= 4'd8) begin
        it[0] = '{data_out: dbyte, has_data: 1'b1, last: 1'b0};
        rem   = t_d - 4'd8;
        n     = 2'd1;
      end else begin
        rem = t_d;
      end
      acc_new = acc_d & ((AccBits'(1) << rem) - AccBits'(1));
    end

    // bare end marker when the final item yields nothing
    if (item.is_last && n == '0) begin
      it[0] = '{data_out: 8'd0, has_data: 1'b0, last: 1'b1};
      n     = 2'd1;
    end
    // flag the final result of the message
    for (int k = 0; k < MaxRes; k++) begin
      if (item.is_last && 2'(k) == n - 2'd1) it[k].last = 1'b1;
    end
  end

  // pack results
  always_comb begin
    res.cnt = n;
    for (int k = 0; k < MaxRes; k++) res.items[k] = it[k];
  end

  // next accumulator state
  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (clear) begin
      acc_nxt = '0;
      cnt_nxt = '0;
    end else if (commit) begin
      if (item.is_last) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = acc_new;
        cnt_nxt = rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/b32_outq.sv
// result queue: takes up to three beats per cycle when there is room, hands out one per cycle unless stalled
module b32_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b32_pkg::step_res_t  res,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output b32_pkg::out_item_t  out_item
);
  import b32_pkg::*;

  out_item_t  q_r   [QueueDep];
  out_item_t  q_nxt [QueueDep];
  logic [2:0] count_r, count_nxt, base;
  logic [2:0] off;
  logic       pop;

  assign out_valid = (count_r != '0);
  assign out_item  = q_r[0];
  assign pop       = out_valid && !out_stall;
  assign base      = count_r - {2'b00, pop};
  assign room      = (base <= 3'(QueueDep - MaxRes));

  // shift on pop, then drop new beats behind the survivors
  always_comb begin
    off = '0;
    for (int i = 0; i < QueueDep; i++) begin
      if (pop && i < QueueDep - 1) q_nxt[i] = q_r[i+1];
      else                          q_nxt[i] = q_r[i];
      off = 3'(i) - base;
      if (push && 3'(i) >= base && off < {1'b0, res.cnt}) begin
        q_nxt[i] = res.items[off[1:0]];
      end
    end
    count_nxt = push ? base + {1'b0, res.cnt} : base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDep; i++) q_r[i] <= q_nxt[i];
  end

endmodule

// File: hw/rtl/base32_codec_unit.sv
// base32 codec top: config registers, input register, step logic, result queue
// an accepted input beat is held in the input register, and its results pass through the result queue
// throughput: one input beat per cycle while the result queue has room; result beats leave
//   at one per cycle unless stalled, so items with more results can stall the input (queue of 4)
// reset (rst_n low, synchronous): mode encode, alphabet zero, state and queue empty
module base32_codec_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  b32_pkg::in_item_t                     in_item,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output b32_pkg::out_item_t                    out_item,
  input  logic                                  cfg_we,
  input  logic [b32_pkg::CfgIdxW-1:0]           cfg_index,
  input  logic [b32_pkg::CfgDataW-1:0]          cfg_wdata
);
  import b32_pkg::*;

  logic                mode_r;
  logic [CfgDataW-1:0] alpha_lo_r, alpha_ml_r, alpha_mh_r, alpha_hi_r;
  alpha_t              alpha;
  in_item_t            item_r;
  logic                item_v_r, item_v_nxt;
  logic                accept, commit, room, clear;
  step_res_t           res;

  assign alpha = {alpha_hi_r, alpha_mh_r, alpha_ml_r, alpha_lo_r};
  assign clear = cfg_we && (cfg_index == CFG_MODE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_ENCODE;
      alpha_lo_r <= '0;
      alpha_ml_r <= '0;
      alpha_mh_r <= '0;
      alpha_hi_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:     mode_r     <= cfg_wdata[0];
        CFG_ALPHA_LO: alpha_lo_r <= cfg_wdata;
        CFG_ALPHA_ML: alpha_ml_r <= cfg_wdata;
        CFG_ALPHA_MH: alpha_mh_r <= cfg_wdata;
        CFG_ALPHA_HI: alpha_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register handshake
  assign commit   = item_v_r && room;
  assign in_stall = item_v_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    item_v_nxt = item_v_r;
    if (accept)      item_v_nxt = 1'b1;
    else if (commit) item_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) item_v_r <= 1'b0;
    else        item_v_r <= item_v_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_item;
  end

  // per-item step
  b32_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .mode   (mode_r),
    .alpha  (alpha),
    .item   (item_r),
    .commit (commit),
    .clear  (clear),
    .res    (res)
  );

  // result queue
  b32_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (commit),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the base32 codec unit
module tb;
  import b32_pkg::*;

  localparam int IdleLimit    = 4000;
  localparam int SettleCycles = 8;
  localparam int RandomItems  = 160;
  localparam int ReportLimit  = 10;
  localparam int GroupBits    = 5;
  localparam int ByteBits     = 8;

  typedef logic [7:0] byte_list_t[$];
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pat_e;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgDataW-1:0]  cfg_wdata;

  // mirrored codec state and registers
  logic                 codec_mode;
  logic [255:0]         alpha_bits;
  logic [AccBits-1:0]   acc_bits;
  logic [CntBits-1:0]   acc_count;

  out_item_t            pending_beats[$];
  int                   mismatch_count = 0;
  int                   idle_cycles = 0;
  int                   burst_left = 0;

  base32_codec_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] char_of(int unsigned idx);
    return alpha_bits[8*idx +: 8];
  endfunction

  // highest matching entry wins, unknown characters give 0
  function automatic int unsigned index_of_char(logic [7:0] ch);
    int unsigned found;
    found = 0;
    for (int i = 0; i < SymCount; i++) begin
      if (alpha_bits[8*i +: 8] == ch) found = i;
    end
    return found;
  endfunction

  // expected result beats for one accepted input beat
  function automatic void base32_step(in_item_t it);
    int unsigned acc;
    int unsigned cnt;
    logic [7:0]  emitted [MaxRes];
    int          n;
    out_item_t   beat;
    acc = acc_bits;
    cnt = acc_count;
    n = 0;
    if (codec_mode == MODE_ENCODE) begin
      acc = ((acc << ByteBits) | it.data_in) & ((1 << AccBits) - 1);
      cnt += ByteBits;
      while (cnt >= GroupBits && n < MaxRes) begin
        cnt -= GroupBits;
        emitted[n] = char_of((acc >> cnt) & (SymCount - 1));
        n++;
      end
      acc &= (1 << cnt) - 1;
      // zero-fill the tail group on the last byte
      if (it.is_last && cnt > 0 && n < MaxRes) begin
        emitted[n] = char_of((acc << (GroupBits - cnt)) & (SymCount - 1));
        n++;
      end
    end else begin
      acc = ((acc << GroupBits) | index_of_char(it.data_in)) & ((1 << AccBits) - 1);
      cnt += GroupBits;
      if (cnt >= ByteBits) begin
        cnt -= ByteBits;
        emitted[n] = 8'((acc >> cnt) & 8'hff);
        n++;
      end
      acc &= (1 << cnt) - 1;
    end
    for (int k = 0; k < n; k++) begin
      beat.data_out = emitted[k];
      beat.has_data = 1'b1;
      beat.last     = it.is_last && (k == n - 1);
      pending_beats.push_back(beat);
    end
    // end of message: bare marker if nothing came out, state cleared
    if (it.is_last) begin
      if (n == 0) begin
        beat.data_out = 8'h00;
        beat.has_data = 1'b0;
        beat.last     = 1'b1;
        pending_beats.push_back(beat);
      end
      acc = 0;
      cnt = 0;
    end
    acc_bits  = acc[AccBits-1:0];
    acc_count = cnt[CntBits-1:0];
  endfunction

  // one input beat, then a random gap at the end of a burst
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    base32_step(it);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 6) == 0) ? 60 : $urandom_range(0, 10);
    end
  endtask

  task automatic send_msg(byte_list_t msg, bit close);
    in_item_t it;
    for (int i = 0; i < msg.size(); i++) begin
      it.data_in = msg[i];
      it.is_last = close && (i == msg.size() - 1);
      send_item(it);
    end
  endtask

  // drain all expected beats, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // register write, mirrored at the same edge
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_MODE: begin
        codec_mode = data[0];
        acc_bits   = '0;
        acc_count  = '0;
      end
      CFG_ALPHA_LO: alpha_bits[63:0]    = data;
      CFG_ALPHA_ML: alpha_bits[127:64]  = data;
      CFG_ALPHA_MH: alpha_bits[191:128] = data;
      CFG_ALPHA_HI: alpha_bits[255:192] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_alphabet(logic [255:0] a);
    for (int r = 0; r < 4; r++) begin
      write_reg(CfgIdxW'(int'(CFG_ALPHA_LO) + r), a[64*r +: 64]);
    end
  endtask

  function automatic logic [255:0] std_alphabet();
    string s = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    logic [255:0] a;
    for (int i = 0; i < SymCount; i++) a[8*i +: 8] = s[i];
    return a;
  endfunction

  function automatic logic [255:0] distinct_alphabet();
    logic [255:0] a;
    bit [255:0]   used;
    logic [7:0]   c;
    used = '0;
    for (int i = 0; i < SymCount; i++) begin
      do c = 8'($urandom_range(0, 255)); while (used[c]);
      used[c] = 1'b1;
      a[8*i +: 8] = c;
    end
    return a;
  endfunction

  // encode: zero alphabet from reset, byte extremes, a whole 40-bit block
  task automatic test_encode_directed();
    send_msg('{8'hff}, 1'b1);
    wait_idle();
    load_alphabet(std_alphabet());
    write_reg(CFG_MODE, CfgDataW'(MODE_ENCODE));
    send_msg('{8'h00}, 1'b1);
    send_msg('{8'hff}, 1'b1);
    send_msg('{8'h66, 8'h6f, 8'h6f, 8'h62, 8'h61}, 1'b1);
    send_msg('{8'h5a, 8'ha5}, 1'b1);
  endtask

  // decode: normal pair, bare end marker, unknown character
  task automatic test_decode_directed();
    wait_idle();
    write_reg(CFG_MODE, CfgDataW'(MODE_DECODE));
    send_msg('{8'h4d, 8'h59}, 1'b1);
    send_msg('{8'h41}, 1'b1);
    send_msg('{8'h21, 8'h42, 8'h43, 8'h44}, 1'b1);
  endtask

  // every entry the same: the highest index must win
  task automatic test_duplicate_chars();
    wait_idle();
    load_alphabet({SymCount{8'h41}});
    send_msg('{8'h41, 8'h41}, 1'b1);
  endtask

  // a mode write mid-message drops the pending bits
  task automatic test_mode_clear();
    wait_idle();
    load_alphabet(std_alphabet());
    send_msg('{8'h42}, 1'b0);
    wait_idle();
    write_reg(CFG_MODE, CfgDataW'(MODE_ENCODE));
    send_msg('{8'h12}, 1'b0);
    wait_idle();
    write_reg(CFG_MODE, CfgDataW'(MODE_ENCODE));
    send_msg('{8'h34}, 1'b1);
  endtask

  // writes past the alphabet registers change nothing
  task automatic test_bad_index();
    wait_idle();
    for (int r = int'(CFG_ALPHA_HI) + 1; r < (1 << CfgIdxW); r++) begin
      write_reg(CfgIdxW'(r), {$urandom, $urandom});
    end
    send_msg('{8'hc3}, 1'b1);
  endtask

  // random phases of settings with mostly well-formed messages
  task automatic test_random();
    int           sent;
    int           budget;
    int           len;
    logic [255:0] a;
    in_item_t     it;
    sent = 0;
    while (sent < RandomItems) begin
      wait_idle();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_MODE, CfgDataW'($urandom_range(0, 1)));
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: a = distinct_alphabet();
        6: a = std_alphabet();
        7: a = {SymCount{8'($urandom_range(0, 255))}};
        8: a = ($urandom_range(0, 1) == 0) ? '0 : '1;
        default: a = {$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom};
      endcase
      load_alphabet(a);
      budget = $urandom_range(15, 35);
      while (budget > 0 && sent < RandomItems) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          // decode mostly uses alphabet characters, some noise
          if (codec_mode == MODE_DECODE && $urandom_range(0, 6) != 0) begin
            it.data_in = alpha_bits[8*$urandom_range(0, SymCount - 1) +: 8];
          end else begin
            it.data_in = 8'($urandom_range(0, 255));
          end
          it.is_last = (i == len - 1) && ($urandom_range(0, 9) != 0);
          send_item(it);
          sent++;
          budget--;
        end
      end
    end
  endtask

  // receiver stall patterns
  initial begin
    stall_pat_e pat;
    int         span;
    out_stall = 1'b0;
    forever begin
      pat  = stall_pat_e'($urandom_range(0, 3));
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(negedge clk);
        case (pat)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // result beat check against the oldest expectation
  always @(posedge clk) begin : check_beat
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        if (mismatch_count < ReportLimit) begin
          $display("unexpected result beat: data=%h has_data=%b last=%b",
                   out_item.data_out, out_item.has_data, out_item.last);
        end
        mismatch_count++;
      end else begin
        want = pending_beats.pop_front();
        if (out_item.data_out !== want.data_out || out_item.has_data !== want.has_data ||
            out_item.last !== want.last) begin
          if (mismatch_count < ReportLimit) begin
            $display("result mismatch: expected data=%h has_data=%b last=%b",
                     want.data_out, want.has_data, want.last);
            $display("  got data=%h has_data=%b last=%b",
                     out_item.data_out, out_item.has_data, out_item.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset, tests in turn, final verdict
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    codec_mode = MODE_ENCODE;
    alpha_bits = '0;
    acc_bits   = '0;
    acc_count  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_encode_directed();
    test_decode_directed();
    test_duplicate_chars();
    test_mode_clear();
    test_bad_index();
    test_random();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
